>>> rtl/ecu_pkg.sv
// shared widths, constants and lane transaction types for the eikonal cell update
package ecu_pkg;

  // number format
  localparam int TW        = 32;
  localparam int FRAC_BITS = 16;

  // derived widths
  localparam int AW        = TW + 1;
  localparam int VV_W      = 2 * TW;
  localparam int FQ_W      = 2 * TW;
  localparam int WD_W      = 2 * TW;
  localparam int RQ_W      = 3 * FRAC_BITS + 1;
  localparam int POS_W     = AW + FQ_W;
  localparam int NEG_W     = 4 * TW - 2 * FRAC_BITS;
  localparam int CMP_W     = (POS_W > NEG_W) ? POS_W : NEG_W;
  localparam int ROOT_W    = (POS_W + 1) / 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int NUM_W     = ((WD_W > ROOT_W + FRAC_BITS) ? WD_W : ROOT_W + FRAC_BITS) + 1;

  // pipeline depths
  localparam int RECIP_LAT = RQ_W + 2;
  localparam int SOLVE_LAT = ROOT_W + TW + 6;

  // constants
  localparam logic [TW-1:0]   TIME_INF = '1;
  localparam logic [FQ_W-1:0] FQ_MAX   = '1;
  localparam logic [TW-1:0]   UNIT_ONE = TW'(64'd1 << FRAC_BITS);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INV_DY = CFG_IDX_W'(1);

  // one solve of the upwind quadratic
  typedef struct packed {
    logic [TW-1:0]    s1;
    logic [AW-1:0]    a;
    logic [TW-1:0]    w2;
    logic [TW-1:0]    d;
    logic [FQ_W-1:0]  fq;
    logic [NEG_W-1:0] neg;
  } lane_in_t;

  typedef struct packed {
    logic          ok;
    logic [TW-1:0] res;
  } lane_out_t;

endpackage

>>> rtl/eikonal_cell_update_2d.sv
// Eikonal cell update: one transaction per cycle through 6 front stages, 3F+3 reciprocal
// stages, 87 solve stages (49 square root bits, TW quotient bits and six more) and the output
// register, at FRAC_BITS = 16; the depth is set by the
// bit-per-stage reciprocal divider, square root and final divider; out_stall halts the
// pipeline only when a finished transaction reaches a full output register, so bubbles drain
// and new transactions are taken while one waits.
module eikonal_cell_update_2d (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ecu_pkg::TW-1:0]        in_own_time,
  input  logic [ecu_pkg::TW-1:0]        in_cell_speed,
  input  logic [ecu_pkg::TW-1:0]        in_x_side_a_time,
  input  logic [ecu_pkg::TW-1:0]        in_x_side_b_time,
  input  logic [ecu_pkg::TW-1:0]        in_y_side_a_time,
  input  logic [ecu_pkg::TW-1:0]        in_y_side_b_time,
  input  logic [3:0]                    in_neighbour_valid,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ecu_pkg::TW-1:0]        out_new_time,
  output logic                          out_improved,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ecu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecu_pkg::TW-1:0]        cfg_data
);
  import ecu_pkg::*;

  typedef struct packed {
    logic [TW-1:0] own;
    logic [TW-1:0] speed;
    logic [TW-1:0] xa;
    logic [TW-1:0] xb;
    logic [TW-1:0] ya;
    logic [TW-1:0] yb;
    logic [3:0]    nv;
  } st0_t;

  typedef struct packed {
    logic [TW-1:0] own;
    logic [TW-1:0] speed;
    logic [TW-1:0] sx;
    logic [TW-1:0] sy;
  } st1_t;

  typedef struct packed {
    logic [TW-1:0] own;
    logic [TW-1:0] s1;
    logic [TW-1:0] s2;
    logic [TW-1:0] w1;
    logic [TW-1:0] w2;
    logic [TW-1:0] d;
    logic          any;
    logic          two;
  } ax_t;

  typedef struct packed {
    ax_t             ax;
    logic [VV_W-1:0] vv;
  } st2_t;

  typedef struct packed {
    ax_t              ax;
    logic [VV_W-1:0]  vv;
    logic [2*TW-1:0]  ww;
    logic [2*TW-1:0]  dd;
    logic [AW-1:0]    a2;
  } st3_t;

  typedef struct packed {
    ax_t              ax;
    logic [VV_W-1:0]  vv;
    logic [AW-1:0]    a2;
    logic [2*TW-1:0]  pp_ll;
    logic [2*TW-1:0]  pp_lh;
    logic [2*TW-1:0]  pp_hl;
    logic [2*TW-1:0]  pp_hh;
  } st4_t;

  typedef struct packed {
    ax_t              ax;
    logic [VV_W-1:0]  vv;
    logic [AW-1:0]    a2;
    logic [NEG_W-1:0] neg;
  } st5_t;

  typedef struct packed {
    ax_t              ax;
    logic [AW-1:0]    a2;
    logic [NEG_W-1:0] neg;
  } dl1_t;

  typedef struct packed {
    logic [TW-1:0] own;
    logic [TW-1:0] s1;
    logic [TW-1:0] s2;
    logic          any;
    logic          two;
  } dl2_t;

  // configuration registers
  logic [TW-1:0] inv_dx_r;
  logic [TW-1:0] inv_dy_r;

  // pipeline registers
  st0_t st0_r;
  st1_t st1_r, st1_nxt;
  st2_t st2_r, st2_nxt;
  st3_t st3_r, st3_nxt;
  st4_t st4_r, st4_nxt;
  st5_t st5_r, st5_nxt;
  dl1_t dl1_r [RECIP_LAT];
  dl2_t dl2_r [SOLVE_LAT];
  logic [5:0]           st_v_r;
  logic [RECIP_LAT-1:0] dl1_v_r;
  logic [SOLVE_LAT-1:0] dl2_v_r;

  logic          out_valid_r;
  logic [TW-1:0] out_time_r, out_time_nxt;
  logic          out_impr_r, out_impr_nxt;

  logic            adv;
  logic            out_load;
  logic [FQ_W-1:0] fq;
  lane_in_t        l1_in, l2_in;
  lane_out_t       l1_out, l2_out;
  logic [4*TW-1:0] prod;
  logic [TW-1:0]   sln1;
  logic            take1, take2;
  dl1_t            dl1_last;
  dl2_t            dl2_last;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_dx_r <= UNIT_ONE;
      inv_dy_r <= UNIT_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INV_DX: inv_dx_r <= cfg_data;
        REG_INV_DY: inv_dy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: hold only when a finished transaction meets a full, stalled output
  assign adv      = !(out_valid_r && out_stall && dl2_v_r[SOLVE_LAT-1]);
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // smaller valid neighbour per axis
  always_comb begin
    st1_nxt.own   = st0_r.own;
    st1_nxt.speed = st0_r.speed;
    st1_nxt.sx    = st0_r.own;
    st1_nxt.sy    = st0_r.own;
    if (st0_r.nv[0] && st0_r.xa < st1_nxt.sx) begin
      st1_nxt.sx = st0_r.xa;
    end
    if (st0_r.nv[1] && st0_r.xb < st1_nxt.sx) begin
      st1_nxt.sx = st0_r.xb;
    end
    if (st0_r.nv[2] && st0_r.ya < st1_nxt.sy) begin
      st1_nxt.sy = st0_r.ya;
    end
    if (st0_r.nv[3] && st0_r.yb < st1_nxt.sy) begin
      st1_nxt.sy = st0_r.yb;
    end
  end

  // qualify and sort axes, x first on a tie; speed squared
  always_comb begin
    st2_nxt.ax.own = st1_r.own;
    st2_nxt.ax.any = (st1_r.sx < st1_r.own) | (st1_r.sy < st1_r.own);
    st2_nxt.ax.two = (st1_r.sx < st1_r.own) & (st1_r.sy < st1_r.own);
    if (st1_r.sy < st1_r.sx) begin
      st2_nxt.ax.s1 = st1_r.sy;
      st2_nxt.ax.w1 = inv_dy_r;
      st2_nxt.ax.s2 = st1_r.sx;
      st2_nxt.ax.w2 = inv_dx_r;
    end else begin
      st2_nxt.ax.s1 = st1_r.sx;
      st2_nxt.ax.w1 = inv_dx_r;
      st2_nxt.ax.s2 = st1_r.sy;
      st2_nxt.ax.w2 = inv_dy_r;
    end
    st2_nxt.ax.d = st2_nxt.ax.s2 - st2_nxt.ax.s1;
    st2_nxt.vv   = VV_W'(st1_r.speed) * VV_W'(st1_r.speed);
  end

  // weight product, gap squared, weight sum
  always_comb begin
    st3_nxt.ax = st2_r.ax;
    st3_nxt.vv = st2_r.vv;
    st3_nxt.ww = (2*TW)'(st2_r.ax.w1) * (2*TW)'(st2_r.ax.w2);
    st3_nxt.dd = (2*TW)'(st2_r.ax.d) * (2*TW)'(st2_r.ax.d);
    st3_nxt.a2 = AW'(st2_r.ax.w1) + AW'(st2_r.ax.w2);
  end

  // partial products of ww * dd
  always_comb begin
    st4_nxt.ax    = st3_r.ax;
    st4_nxt.vv    = st3_r.vv;
    st4_nxt.a2    = st3_r.a2;
    st4_nxt.pp_ll = (2*TW)'(st3_r.ww[TW-1:0])    * (2*TW)'(st3_r.dd[TW-1:0]);
    st4_nxt.pp_lh = (2*TW)'(st3_r.ww[TW-1:0])    * (2*TW)'(st3_r.dd[2*TW-1:TW]);
    st4_nxt.pp_hl = (2*TW)'(st3_r.ww[2*TW-1:TW]) * (2*TW)'(st3_r.dd[TW-1:0]);
    st4_nxt.pp_hh = (2*TW)'(st3_r.ww[2*TW-1:TW]) * (2*TW)'(st3_r.dd[2*TW-1:TW]);
  end

  // negative term, scaled down by 2^(2F)
  always_comb begin
    prod = (4*TW)'(st4_r.pp_ll)
         + ((4*TW)'(st4_r.pp_lh) << TW)
         + ((4*TW)'(st4_r.pp_hl) << TW)
         + ((4*TW)'(st4_r.pp_hh) << (2*TW));
    st5_nxt.ax  = st4_r.ax;
    st5_nxt.vv  = st4_r.vv;
    st5_nxt.a2  = st4_r.a2;
    st5_nxt.neg = prod[4*TW-1:2*FRAC_BITS];
  end

  // front stage data
  always_ff @(posedge clk) begin
    if (adv) begin
      st0_r.own   <= in_own_time;
      st0_r.speed <= in_cell_speed;
      st0_r.xa    <= in_x_side_a_time;
      st0_r.xb    <= in_x_side_b_time;
      st0_r.ya    <= in_y_side_a_time;
      st0_r.yb    <= in_y_side_b_time;
      st0_r.nv    <= in_neighbour_valid;
      st1_r       <= st1_nxt;
      st2_r       <= st2_nxt;
      st3_r       <= st3_nxt;
      st4_r       <= st4_nxt;
      st5_r       <= st5_nxt;
      dl1_r[0]    <= '{ax: st5_r.ax, a2: st5_r.a2, neg: st5_r.neg};
      for (int i = 1; i < RECIP_LAT; i++) begin
        dl1_r[i] <= dl1_r[i-1];
      end
      dl2_r[0]    <= '{own: dl1_last.ax.own, s1: dl1_last.ax.s1, s2: dl1_last.ax.s2,
                       any: dl1_last.ax.any, two: dl1_last.ax.two};
      for (int i = 1; i < SOLVE_LAT; i++) begin
        dl2_r[i] <= dl2_r[i-1];
      end
    end
  end

  // valid bits alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r  <= '0;
      dl1_v_r <= '0;
      dl2_v_r <= '0;
    end else if (adv) begin
      st_v_r  <= {st_v_r[4:0], in_valid};
      dl1_v_r <= {dl1_v_r[RECIP_LAT-2:0], st_v_r[5]};
      dl2_v_r <= {dl2_v_r[SOLVE_LAT-2:0], dl1_v_r[RECIP_LAT-1]};
    end
  end

  assign dl1_last = dl1_r[RECIP_LAT-1];
  assign dl2_last = dl2_r[SOLVE_LAT-1];

  // reciprocal of speed squared
  ecu_recip u_recip (
    .clk (clk),
    .en  (adv),
    .vv  (st5_r.vv),
    .fq  (fq)
  );

  // one-axis and two-axis solves side by side
  always_comb begin
    l1_in.s1  = dl1_last.ax.s1;
    l1_in.a   = AW'(dl1_last.ax.w1);
    l1_in.w2  = '0;
    l1_in.d   = '0;
    l1_in.fq  = fq;
    l1_in.neg = '0;
    l2_in.s1  = dl1_last.ax.s1;
    l2_in.a   = dl1_last.a2;
    l2_in.w2  = dl1_last.ax.w2;
    l2_in.d   = dl1_last.ax.d;
    l2_in.fq  = fq;
    l2_in.neg = dl1_last.neg;
  end

  ecu_solve u_solve_one (
    .clk  (clk),
    .en   (adv),
    .din  (l1_in),
    .dout (l1_out)
  );

  ecu_solve u_solve_two (
    .clk  (clk),
    .en   (adv),
    .din  (l2_in),
    .dout (l2_out)
  );

  // causality tests and minimum
  always_comb begin
    take1 = dl2_last.any && l1_out.ok && (l1_out.res > dl2_last.s1)
          && (l1_out.res < dl2_last.own);
    sln1  = take1 ? l1_out.res : dl2_last.own;
    take2 = dl2_last.two && !(sln1 < dl2_last.s2) && l2_out.ok
          && (l2_out.res > dl2_last.s2) && (l2_out.res < sln1);
    out_time_nxt = take2 ? l2_out.res : sln1;
    out_impr_nxt = (out_time_nxt < dl2_last.own);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= dl2_v_r[SOLVE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_time_r <= out_time_nxt;
      out_impr_r <= out_impr_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_new_time = out_time_r;
  assign out_improved = out_impr_r;

endmodule

>>> rtl/ecu_recip.sv
// pipelined restoring divider forming 2^(3F) / speed^2, saturated
module ecu_recip (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ecu_pkg::VV_W-1:0]  vv,
  output logic [ecu_pkg::FQ_W-1:0]  fq
);
  import ecu_pkg::*;

  typedef struct packed {
    logic [VV_W-1:0] r;
    logic [RQ_W-1:0] q;
    logic [VV_W-1:0] den;
  } rc_t;

  rc_t             rc_r [RQ_W+1];
  logic [FQ_W-1:0] fq_r;

  // first stage takes the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rc_r[0] <= '{r: '0, q: '0, den: vv};
    end
  end

  // one quotient bit per stage, the only numerator bit enters at the first step
  for (genvar k = 0; k < RQ_W; k++) begin : g_stage
    logic [VV_W:0] trial;
    logic [VV_W:0] diff;
    logic          take;
    rc_t           nxt;

    always_comb begin
      trial    = {rc_r[k].r, ((k == 0) ? 1'b1 : 1'b0)};
      diff     = trial - {1'b0, rc_r[k].den};
      take     = (trial >= {1'b0, rc_r[k].den});
      nxt.den  = rc_r[k].den;
      nxt.r    = take ? diff[VV_W-1:0] : trial[VV_W-1:0];
      nxt.q    = {rc_r[k].q[RQ_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rc_r[k+1] <= nxt;
      end
    end
  end

  // zero speed gives the largest value
  always_ff @(posedge clk) begin
    if (en) begin
      if (rc_r[RQ_W].den == '0 || rc_r[RQ_W].q > RQ_W'(FQ_MAX)) begin
        fq_r <= FQ_MAX;
      end else begin
        fq_r <= FQ_W'(rc_r[RQ_W].q);
      end
    end
  end

  assign fq = fq_r;

endmodule

>>> rtl/ecu_solve.sv
// one upwind quadratic solve: product, discriminant, square root, divide, add
module ecu_solve (
  input  logic                clk,
  input  logic                en,
  input  ecu_pkg::lane_in_t   din,
  output ecu_pkg::lane_out_t  dout
);
  import ecu_pkg::*;

  typedef struct packed {
    logic [WD_W-1:0]  p_ll;
    logic [WD_W-1:0]  p_lh;
    logic             a_top;
    logic [FQ_W-1:0]  fq;
    logic [WD_W-1:0]  wd;
    logic [NEG_W-1:0] neg;
    logic [TW-1:0]    s1;
    logic [AW-1:0]    a;
    logic             az;
  } s0_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [NEG_W-1:0] neg;
    logic [WD_W-1:0]  wd;
    logic [TW-1:0]    s1;
    logic [AW-1:0]    a;
    logic             az;
  } s1_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  x;
    logic [WD_W-1:0]   wd;
    logic [TW-1:0]     s1;
    logic [AW-1:0]     a;
    logic              skip;
  } sq_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [TW-1:0]    s1;
    logic [AW-1:0]    a;
    logic             skip;
  } nm_t;

  typedef struct packed {
    logic [AW-1:0] r;
    logic [TW-1:0] lo;
    logic [TW-1:0] q;
    logic [AW-1:0] a;
    logic [TW-1:0] s1;
    logic          sat;
    logic          skip;
  } dv_t;

  s0_t       s0_r, s0_nxt;
  s1_t       s1_r, s1_nxt;
  sq_t       sq_r [ROOT_W+1];
  sq_t       sq0_nxt;
  nm_t       nm_r, nm_nxt;
  dv_t       dv_r [TW+1];
  dv_t       dv0_nxt;
  lane_out_t dout_r, dout_nxt;

  logic [CMP_W:0] cmp_diff;
  logic [TW:0]    sum;

  // partial products of a * fq and the cross term
  always_comb begin
    s0_nxt.p_ll  = WD_W'(din.a[TW-1:0]) * WD_W'(din.fq[TW-1:0]);
    s0_nxt.p_lh  = WD_W'(din.a[TW-1:0]) * WD_W'(din.fq[FQ_W-1:TW]);
    s0_nxt.a_top = din.a[AW-1];
    s0_nxt.fq    = din.fq;
    s0_nxt.wd    = WD_W'(din.w2) * WD_W'(din.d);
    s0_nxt.neg   = din.neg;
    s0_nxt.s1    = din.s1;
    s0_nxt.a     = din.a;
    s0_nxt.az    = (din.a == '0);
  end

  // sum of partials
  always_comb begin
    s1_nxt.pos = POS_W'(s0_r.p_ll) + (POS_W'(s0_r.p_lh) << TW)
               + (s0_r.a_top ? (POS_W'(s0_r.fq) << TW) : POS_W'(0));
    s1_nxt.neg = s0_r.neg;
    s1_nxt.wd  = s0_r.wd;
    s1_nxt.s1  = s0_r.s1;
    s1_nxt.a   = s0_r.a;
    s1_nxt.az  = s0_r.az;
  end

  // discriminant and skip on negative or zero weight
  always_comb begin
    cmp_diff     = {1'b0, CMP_W'(s1_r.pos)} - {1'b0, CMP_W'(s1_r.neg)};
    sq0_nxt.rem  = '0;
    sq0_nxt.root = '0;
    sq0_nxt.x    = RAD_W'(cmp_diff[POS_W-1:0]);
    sq0_nxt.wd   = s1_r.wd;
    sq0_nxt.s1   = s1_r.s1;
    sq0_nxt.a    = s1_r.a;
    sq0_nxt.skip = s1_r.az | cmp_diff[CMP_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r    <= s0_nxt;
      s1_r    <= s1_nxt;
      sq_r[0] <= sq0_nxt;
    end
  end

  // digit-by-digit square root, one root bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             take;
    sq_t              nxt;

    always_comb begin
      t        = {sq_r[k].rem, sq_r[k].x[RAD_W-1 -: 2]};
      trial    = (REM_W+2)'({sq_r[k].root, 2'b01});
      diff     = t - trial;
      take     = (t >= trial);
      nxt      = sq_r[k];
      nxt.rem  = take ? diff[REM_W-1:0] : t[REM_W-1:0];
      nxt.root = {sq_r[k].root[ROOT_W-2:0], take};
      nxt.x    = sq_r[k].x << 2;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k+1] <= nxt;
      end
    end
  end

  // numerator w2*d + root * 2^F
  always_comb begin
    nm_nxt.num  = NUM_W'(sq_r[ROOT_W].wd) + (NUM_W'(sq_r[ROOT_W].root) << FRAC_BITS);
    nm_nxt.s1   = sq_r[ROOT_W].s1;
    nm_nxt.a    = sq_r[ROOT_W].a;
    nm_nxt.skip = sq_r[ROOT_W].skip;
  end

  // quotient of 2^TW or more saturates, otherwise the high part starts the remainder
  always_comb begin
    dv0_nxt.sat  = (nm_r.num[NUM_W-1:TW] >= (NUM_W-TW)'(nm_r.a));
    dv0_nxt.r    = nm_r.num[TW+AW-1:TW];
    dv0_nxt.lo   = nm_r.num[TW-1:0];
    dv0_nxt.q    = '0;
    dv0_nxt.a    = nm_r.a;
    dv0_nxt.s1   = nm_r.s1;
    dv0_nxt.skip = nm_r.skip;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_r    <= nm_nxt;
      dv_r[0] <= dv0_nxt;
    end
  end

  // restoring division by a, one quotient bit per stage
  for (genvar k = 0; k < TW; k++) begin : g_div
    logic [AW:0] t;
    logic [AW:0] diff;
    logic        take;
    dv_t         nxt;

    always_comb begin
      t      = {dv_r[k].r, dv_r[k].lo[TW-1]};
      diff   = t - {1'b0, dv_r[k].a};
      take   = (t >= {1'b0, dv_r[k].a});
      nxt    = dv_r[k];
      nxt.r  = take ? diff[AW-1:0] : t[AW-1:0];
      nxt.lo = dv_r[k].lo << 1;
      nxt.q  = {dv_r[k].q[TW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1] <= nxt;
      end
    end
  end

  // root value s1 + delta, saturating
  always_comb begin
    sum          = {1'b0, dv_r[TW].s1} + {1'b0, dv_r[TW].q};
    dout_nxt.ok  = ~dv_r[TW].skip;
    dout_nxt.res = (dv_r[TW].sat | sum[TW]) ? TIME_INF : sum[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

>>> rtl/ecu_checker.sv
// port-level checks on the eikonal cell update, bound to the top level
module ecu_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [ecu_pkg::TW-1:0] out_new_time,
  input logic                   out_improved
);
  import ecu_pkg::*;

  // reset empties the output and frees the input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  // input back-pressure only while a result waits under stall
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // a waiting result holds its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_time) && $stable(out_improved))
    else $error("stalled result changed");

  // an improved time is never infinity
  a_improved_finite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_improved |-> out_new_time != TIME_INF)
    else $error("improved result at infinity");

endmodule

bind eikonal_cell_update_2d ecu_checker u_ecu_checker (.*);
